// ===== hdl/tlb_page_table_translator_core_macros.svh =====
// assertion macros for the tlb page table translator
`ifndef TLB_PAGE_TABLE_TRANSLATOR_CORE_MACROS_SVH
`define TLB_PAGE_TABLE_TRANSLATOR_CORE_MACROS_SVH

`ifndef SYNTH

`define TLBPT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("tlbpt assertion failed");

`define TLBPT_ASSERT_NEVER(lbl, clk, rstn, cond) \
  `TLBPT_ASSERT(lbl, clk, rstn, !(cond))

`else

`define TLBPT_ASSERT(lbl, clk, rstn, prop)

`define TLBPT_ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

// ===== hdl/tlbpt_pkg.sv =====
// shared constants for the tlb page table translator
package tlbpt_pkg;

  localparam int unsigned TLB_ENTRIES_DEF  = 16;
  localparam int unsigned PAGE_BITS_DEF    = 10;
  localparam int unsigned OFFSET_WIDTH_DEF = 10;

endpackage

// ===== hdl/tlbpt_if.sv =====
// valid/ready channel interfaces for address and translation beats
interface tlbpt_in_if #(
  parameter int unsigned PAGE_BITS    = tlbpt_pkg::PAGE_BITS_DEF,
  parameter int unsigned OFFSET_WIDTH = tlbpt_pkg::OFFSET_WIDTH_DEF
);
  logic                              valid;
  logic                              ready;
  logic [PAGE_BITS+OFFSET_WIDTH-1:0] virtual_address;

  modport source (output valid, output virtual_address, input ready);
  modport sink   (input valid, input virtual_address, output ready);
endinterface

interface tlbpt_out_if #(
  parameter int unsigned PAGE_BITS    = tlbpt_pkg::PAGE_BITS_DEF,
  parameter int unsigned OFFSET_WIDTH = tlbpt_pkg::OFFSET_WIDTH_DEF
);
  logic                              valid;
  logic                              ready;
  logic [PAGE_BITS+OFFSET_WIDTH-1:0] phys_addr;
  logic                              tlb_hit;
  logic                              page_fault;

  modport source (output valid, output phys_addr, output tlb_hit,
                  output page_fault, input ready);
  modport sink   (input valid, input phys_addr, input tlb_hit,
                  input page_fault, output ready);
endinterface

// ===== hdl/tlbpt_ram.sv =====
// generic single write port ram with registered read
module tlbpt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/tlbpt_tlb.sv =====
// fully associative tlb with fifo replacement
`include "tlb_page_table_translator_core_macros.svh"

module tlbpt_tlb #(
  parameter int unsigned TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEF,
  parameter int unsigned PAGE_BITS   = tlbpt_pkg::PAGE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [PAGE_BITS-1:0] lookup_page,
  output logic                 hit,
  output logic [PAGE_BITS-1:0] hit_frame,
  input  logic                 upd_en,
  input  logic [PAGE_BITS-1:0] upd_page,
  input  logic [PAGE_BITS-1:0] upd_frame
);

  localparam int unsigned PTR_W = $clog2(TLB_ENTRIES);

  logic [TLB_ENTRIES-1:0] tlb_valid_r;
  logic [PAGE_BITS-1:0]   tlb_page_r  [TLB_ENTRIES];
  logic [PAGE_BITS-1:0]   tlb_frame_r [TLB_ENTRIES];
  logic [PTR_W-1:0]       ptr_r;
  logic [PTR_W-1:0]       ptr_nxt;
  logic [TLB_ENTRIES-1:0] match;
  logic [TLB_ENTRIES-1:0] first;

  // parallel compare, lowest index wins
  always_comb begin
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      match[i] = tlb_valid_r[i] && (tlb_page_r[i] == lookup_page);
    end
  end

  assign first = match & (~match + TLB_ENTRIES'(1));
  assign hit   = |match;

  always_comb begin
    hit_frame = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      hit_frame = hit_frame | ({PAGE_BITS{first[i]}} & tlb_frame_r[i]);
    end
  end

  always_comb begin
    if (ptr_r == PTR_W'(TLB_ENTRIES - 1)) begin
      ptr_nxt = '0;
    end else begin
      ptr_nxt = ptr_r + PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tlb_valid_r <= '0;
      ptr_r       <= '0;
    end else if (upd_en) begin
      tlb_valid_r[ptr_r] <= 1'b1;
      ptr_r              <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_en) begin
      tlb_page_r[ptr_r]  <= upd_page;
      tlb_frame_r[ptr_r] <= upd_frame;
    end
  end

  `TLBPT_ASSERT(a_match_onehot0, clk, rst_n, $onehot0(match))
  `TLBPT_ASSERT_NEVER(a_ptr_range, clk, rst_n, ptr_r > PTR_W'(TLB_ENTRIES - 1))
  `TLBPT_ASSERT(a_upd_sets_valid, clk, rst_n, upd_en |=> tlb_valid_r[$past(ptr_r)])

endmodule

// ===== hdl/tlb_page_table_translator_core.sv =====
// tlb and demand-paged page table address translator, top level
//
//  channel  dir  beat contents                            handshake
//  in_bus   in   virtual_address                          valid/ready
//  out_bus  out  phys_addr, tlb_hit, page_fault           valid/ready
//
// after the sweep, one beat per cycle sustained while out_bus.ready is high; each
// beat passes the input register (with page table read), then the result register
// after reset the page table valid bits are swept clear, entry by entry,
// with in_bus.ready low
// a stalled result holds in the output register; outside the sweep the input
// stage takes a new beat when it is empty or its beat moves on into the result register in the same cycle
`include "tlb_page_table_translator_core_macros.svh"

module tlb_page_table_translator_core #(
  parameter int unsigned TLB_ENTRIES  = tlbpt_pkg::TLB_ENTRIES_DEF,
  parameter int unsigned PAGE_BITS    = tlbpt_pkg::PAGE_BITS_DEF,
  parameter int unsigned OFFSET_WIDTH = tlbpt_pkg::OFFSET_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  tlbpt_in_if.sink     in_bus,
  tlbpt_out_if.source  out_bus
);

  localparam int unsigned ADDR_W     = PAGE_BITS + OFFSET_WIDTH;
  localparam int unsigned PT_W       = PAGE_BITS + 1;
  localparam int unsigned PAGE_COUNT = 1 << PAGE_BITS;

  logic                    clr_busy_r;
  logic [PAGE_BITS-1:0]    clr_idx_r;
  logic                    s1_valid_r;
  logic [ADDR_W-1:0]       s1_va_r;
  logic                    out_valid_r;
  logic [ADDR_W-1:0]       out_pa_r;
  logic                    out_hit_r;
  logic                    out_fault_r;
  logic [PAGE_BITS:0]      nfree_r;

  logic                    in_ready;
  logic                    in_acc;
  logic                    s1_adv;
  logic [PAGE_BITS-1:0]    s1_page;
  logic [OFFSET_WIDTH-1:0] s1_off;
  logic                    tlb_hit;
  logic [PAGE_BITS-1:0]    tlb_frame;
  logic [PT_W-1:0]         pt_rd_data;
  logic                    pt_valid;
  logic [PAGE_BITS-1:0]    pt_frame;
  logic                    s1_fault;
  logic [PAGE_BITS-1:0]    s1_frame;
  logic                    pt_wr_en;
  logic [PAGE_BITS-1:0]    pt_wr_addr;
  logic [PT_W-1:0]         pt_wr_data;
  logic                    nfree_inc;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_bus.ready);
  assign in_ready = !clr_busy_r && (!s1_valid_r || s1_adv);
  assign in_acc   = in_bus.valid && in_ready;

  assign in_bus.ready = in_ready;

  assign s1_page = s1_va_r[ADDR_W-1:OFFSET_WIDTH];
  assign s1_off  = s1_va_r[OFFSET_WIDTH-1:0];

  assign pt_valid = pt_rd_data[PAGE_BITS];
  assign pt_frame = pt_rd_data[PAGE_BITS-1:0];

  assign s1_fault = !tlb_hit && !pt_valid;

  assign nfree_inc = s1_adv && s1_fault && (nfree_r < (PAGE_BITS+1)'(PAGE_COUNT));

  always_comb begin
    priority if (tlb_hit) begin
      s1_frame = tlb_frame;
    end else if (pt_valid) begin
      s1_frame = pt_frame;
    end else begin
      s1_frame = nfree_r[PAGE_BITS-1:0];
    end
  end

  // sweep owns the write port until the table is clear
  always_comb begin
    if (clr_busy_r) begin
      pt_wr_en   = 1'b1;
      pt_wr_addr = clr_idx_r;
      pt_wr_data = '0;
    end else begin
      pt_wr_en   = s1_adv && s1_fault;
      pt_wr_addr = s1_page;
      pt_wr_data = {1'b1, s1_frame};
    end
  end

  tlbpt_ram #(
    .WIDTH (PT_W),
    .DEPTH (PAGE_COUNT)
  ) u_pt_ram (
    .clk     (clk),
    .wr_en   (pt_wr_en),
    .wr_addr (pt_wr_addr),
    .wr_data (pt_wr_data),
    .rd_en   (in_acc),
    .rd_addr (in_bus.virtual_address[ADDR_W-1:OFFSET_WIDTH]),
    .rd_data (pt_rd_data)
  );

  tlbpt_tlb #(
    .TLB_ENTRIES (TLB_ENTRIES),
    .PAGE_BITS   (PAGE_BITS)
  ) u_tlb (
    .clk         (clk),
    .rst_n       (rst_n),
    .lookup_page (s1_page),
    .hit         (tlb_hit),
    .hit_frame   (tlb_frame),
    .upd_en      (s1_adv && !tlb_hit),
    .upd_page    (s1_page),
    .upd_frame   (s1_frame)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r  <= 1'b1;
      clr_idx_r   <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      nfree_r     <= '0;
    end else begin
      if (clr_busy_r) begin
        clr_idx_r <= clr_idx_r + PAGE_BITS'(1);
        if (clr_idx_r == {PAGE_BITS{1'b1}}) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
      if (nfree_inc) begin
        nfree_r <= nfree_r + (PAGE_BITS+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_va_r <= in_bus.virtual_address;
    end
    if (s1_adv) begin
      out_pa_r    <= {s1_frame, s1_off};
      out_hit_r   <= tlb_hit;
      out_fault_r <= s1_fault;
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.phys_addr  = out_pa_r;
  assign out_bus.tlb_hit    = out_hit_r;
  assign out_bus.page_fault = out_fault_r;

  `TLBPT_ASSERT_NEVER(a_no_accept_in_clear, clk, rst_n, clr_busy_r && in_ready)
  `TLBPT_ASSERT_NEVER(a_hit_fault_excl, clk, rst_n, out_valid_r && out_hit_r && out_fault_r)
  `TLBPT_ASSERT_NEVER(a_nfree_bound, clk, rst_n, nfree_r > (PAGE_BITS+1)'(PAGE_COUNT))
  `TLBPT_ASSERT(a_fault_alloc, clk, rst_n, nfree_inc |=> nfree_r == $past(nfree_r) + (PAGE_BITS+1)'(1))

endmodule
